>>> hw/rtl/nlcf_pkg.sv
// Shared types, character codes and helper functions of the NMEA line checksum framer.
package nlcf_pkg;

   // Character codes that steer the framing.
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;

   // Ceiling of the saturating checksum-error counter.
   localparam logic [15:0] ERR_COUNT_MAX = 16'hFFFF;

   // Verdict reported for each line.
   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_NO_SUM   = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_OVERLONG = 2'd3
   } status_type;

   // One result beat.
   typedef struct packed {
      status_type  status;
      logic [7:0]  line_length;
      logic [7:0]  computed_sum;
      logic [7:0]  received_sum;
      logic [15:0] checksum_errors;
   } result_type;

   // A hex digit as read from one character.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // True for a decimal digit character.
   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Reads one character as a hex digit of either case.
   function automatic hex_digit_type hex_value(input logic [7:0] c);
      hex_digit_type h;
      logic [7:0]    diff;
      h.valid = 1'b0;
      h.value = 4'd0;
      diff    = 8'd0;
      if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         diff    = c - CHAR_ZERO;
         h.valid = 1'b1;
         h.value = diff[3:0];
      end else if ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) begin
         diff    = c - CHAR_LO_A + 8'd10;
         h.valid = 1'b1;
         h.value = diff[3:0];
      end else if ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) begin
         diff    = c - CHAR_UP_A + 8'd10;
         h.valid = 1'b1;
         h.value = diff[3:0];
      end
      return h;
   endfunction

endpackage

>>> hw/rtl/nmea_line_checksum_framer_unit.sv
// Top level of the NMEA line checksum framer: input register, line logic and result register.
//
//   channel | direction | payload                                       | handshake
//   req     | in        | rx_byte                                       | req_valid/req_ready
//   rsp     | out       | status, line_length, computed_sum,            | rsp_valid/rsp_ready
//           |           | received_sum, checksum_errors                 |
//
// One byte is taken every cycle unless a newline waits for the result register; a result
// is presented after its newline byte passes the input register and then the result register.
// The byte in the input register updates the line state as it leaves; only a newline
// has to wait for room in the result register, so a stalled consumer stops the input
// side only when a newline meets a full result register.
// Synchronous reset empties both registers, returns the line state to its start and the error
// counter to zero.
module nmea_line_checksum_framer_unit #(
   parameter int LINE_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_line_length,
   output logic [7:0]  rsp_computed_sum,
   output logic [7:0]  rsp_received_sum,
   output logic [15:0] rsp_checksum_errors
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 is_newline;
   logic                 consume;
   nlcf_pkg::result_type line_result;
   nlcf_pkg::result_type rsp_data;

   // A held byte leaves unless it is a newline that finds the result slot occupied and not being taken.
   assign is_newline  = (in_byte_ff == nlcf_pkg::CHAR_LF);
   assign consume     = in_valid_ff && (!is_newline || !rsp_valid || rsp_ready);
   assign req_ready   = !in_valid_ff || consume;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !consume);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   nlcf_line_state #(
      .LINE_MAX(LINE_MAX)
   ) u_line_state (
      .clock  (clock),
      .reset  (reset),
      .step   (consume),
      .rx_byte(in_byte_ff),
      .result (line_result)
   );

   nlcf_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (consume && is_newline),
      .load_data(line_result),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Result fields onto their ports.
   assign rsp_status          = rsp_data.status;
   assign rsp_line_length     = rsp_data.line_length;
   assign rsp_computed_sum    = rsp_data.computed_sum;
   assign rsp_received_sum    = rsp_data.received_sum;
   assign rsp_checksum_errors = rsp_data.checksum_errors;

endmodule

>>> hw/rtl/nlcf_line_state.sv
// Per-line framing state, running checksum and verdict logic of the line checksum framer.
module nlcf_line_state #(
   parameter int LINE_MAX = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output nlcf_pkg::result_type result
);

   localparam int CNT_W = $clog2(LINE_MAX + 1);
   localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LINE_MAX);

   logic             in_prefix_ff, in_prefix_in;
   logic [CNT_W-1:0] raw_count_ff, raw_count_in;
   logic [CNT_W-1:0] strip_count_ff, strip_count_in;
   logic             dollar_ff, dollar_in;
   logic [7:0]       xor_acc_ff, xor_acc_in;
   logic [7:0]       recent_ff [3];
   logic [7:0]       recent_in [3];
   logic             overlong_ff, overlong_in;
   logic [15:0]      err_count_ff, err_count_in;

   logic             feed;
   logic [CNT_W-1:0] raw_next;
   logic [CNT_W-1:0] feed_base;
   logic [CNT_W-1:0] feed_count;
   logic [CNT_W-1:0] strip_eff;
   logic [LEN_W-1:0] strip_wide;
   logic             has_sum;
   nlcf_pkg::hex_digit_type h1, h2;
   logic [7:0]       comp_sum;
   logic [7:0]       recv_sum;
   logic             mismatch;

   // Checksum verdict for the line that a newline closes.
   always_comb begin
      strip_eff  = in_prefix_ff ? raw_count_ff : strip_count_ff;
      strip_wide = LEN_W'(strip_eff);
      has_sum    = dollar_ff && (strip_eff > CNT_W'(4)) && (recent_ff[2] == nlcf_pkg::CHAR_STAR);
      h1         = nlcf_pkg::hex_value(recent_ff[1]);
      h2         = nlcf_pkg::hex_value(recent_ff[0]);
      comp_sum   = xor_acc_ff ^ recent_ff[0] ^ recent_ff[1] ^ recent_ff[2];
      if (!h1.valid) begin
         recv_sum = 8'd0;
      end else if (h2.valid) begin
         recv_sum = {h1.value, h2.value};
      end else begin
         recv_sum = {4'd0, h1.value};
      end
      mismatch = !overlong_ff && has_sum && (recv_sum != comp_sum);

      if (mismatch && (err_count_ff != nlcf_pkg::ERR_COUNT_MAX)) begin
         err_count_in = err_count_ff + 16'd1;
      end else begin
         err_count_in = err_count_ff;
      end

      priority if (overlong_ff) begin
         result.status = nlcf_pkg::STATUS_OVERLONG;
      end else if (!has_sum) begin
         result.status = nlcf_pkg::STATUS_NO_SUM;
      end else if (mismatch) begin
         result.status = nlcf_pkg::STATUS_MISMATCH;
      end else begin
         result.status = nlcf_pkg::STATUS_GOOD;
      end
      result.line_length     = (strip_wide > LEN_W'(255)) ? 8'hFF : strip_wide[7:0];
      result.computed_sum    = (!overlong_ff && has_sum) ? comp_sum : 8'd0;
      result.received_sum    = (!overlong_ff && has_sum) ? recv_sum : 8'd0;
      result.checksum_errors = err_count_in;
   end

   // Next state for an ordinary character: prefix stripping, counting and the XOR.
   always_comb begin
      in_prefix_in   = in_prefix_ff;
      raw_count_in   = raw_count_ff;
      strip_count_in = strip_count_ff;
      dollar_in      = dollar_ff;
      xor_acc_in     = xor_acc_ff;
      recent_in      = recent_ff;
      overlong_in    = overlong_ff;
      feed           = 1'b0;
      feed_base      = strip_count_ff;
      feed_count     = strip_count_ff;
      raw_next       = raw_count_ff + CNT_W'(1);

      if (raw_count_ff < LIMIT) begin
         raw_count_in = raw_next;
         if (raw_next >= LIMIT) begin
            overlong_in = 1'b1;
         end
         if (!in_prefix_ff) begin
            feed = 1'b1;
         end else if (!nlcf_pkg::is_digit(rx_byte)) begin
            in_prefix_in = 1'b0;
            if (rx_byte == nlcf_pkg::CHAR_TAB) begin
               strip_count_in = '0;
            end else begin
               feed      = 1'b1;
               feed_base = raw_count_ff;
            end
         end
      end

      if (feed) begin
         feed_count     = (feed_base < LIMIT) ? feed_base + CNT_W'(1) : feed_base;
         strip_count_in = feed_count;
         if (feed_count == CNT_W'(1)) begin
            dollar_in = (rx_byte == nlcf_pkg::CHAR_DOLLAR);
         end else begin
            xor_acc_in = xor_acc_ff ^ rx_byte;
         end
         recent_in[2] = recent_ff[1];
         recent_in[1] = recent_ff[0];
         recent_in[0] = rx_byte;
      end
   end

   // State registers; a newline returns the line state to its start.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_prefix_ff   <= 1'b1;
         raw_count_ff   <= '0;
         strip_count_ff <= '0;
         dollar_ff      <= 1'b0;
         xor_acc_ff     <= 8'd0;
         recent_ff[0]   <= 8'd0;
         recent_ff[1]   <= 8'd0;
         recent_ff[2]   <= 8'd0;
         overlong_ff    <= 1'b0;
         err_count_ff   <= 16'd0;
      end else if (step && (rx_byte == nlcf_pkg::CHAR_LF)) begin
         in_prefix_ff   <= 1'b1;
         raw_count_ff   <= '0;
         strip_count_ff <= '0;
         dollar_ff      <= 1'b0;
         xor_acc_ff     <= 8'd0;
         recent_ff[0]   <= 8'd0;
         recent_ff[1]   <= 8'd0;
         recent_ff[2]   <= 8'd0;
         overlong_ff    <= 1'b0;
         err_count_ff   <= err_count_in;
      end else if (step && (rx_byte != nlcf_pkg::CHAR_CR)) begin
         in_prefix_ff   <= in_prefix_in;
         raw_count_ff   <= raw_count_in;
         strip_count_ff <= strip_count_in;
         dollar_ff      <= dollar_in;
         xor_acc_ff     <= xor_acc_in;
         recent_ff      <= recent_in;
         overlong_ff    <= overlong_in;
      end
   end

endmodule

>>> hw/rtl/nlcf_rsp_reg.sv
// Result register that holds one finished beat until the consumer takes it.
module nlcf_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  nlcf_pkg::result_type load_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output nlcf_pkg::result_type rsp_data
);

   logic                 valid_ff, valid_in;
   nlcf_pkg::result_type data_ff;

   // The slot fills on a load and empties when its beat is taken.
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
